[src/a2bc_pkg.sv]
// Shared types, constants and index helper for the Argon2 block compressor.
`default_nettype none
package a2bc_pkg;

	localparam logic OP_SBOX  = 1'b0;
	localparam logic OP_BLOCK = 1'b1;

	localparam logic CFG_XOR_MODE = 1'b0;
	localparam logic CFG_USE_SBOX = 1'b1;

	localparam int MIX_STEPS = 96;
	localparam logic [6:0] LAST_WORD_IDX = 7'd127;
	localparam logic [31:0] LOW32 = 32'hFFFF_FFFF;

	// where a registered work/base read lands in the cycle after it is issued
	typedef enum logic [2:0] {
		DST_NONE  = 3'd0,
		DST_SEED0 = 3'd1,
		DST_SEED1 = 3'd2,
		DST_QUAD  = 3'd3,
		DST_EMIT  = 3'd4
	} rd_dst_t;

	typedef struct packed {
		logic [6:0] rd_addr;
		rd_dst_t    rd_dst;
		logic [1:0] rd_j;
		logic       wr_en;
		logic [6:0] wr_addr;
		logic [1:0] wr_j;
		logic       mix_mul;
		logic       mix_upd;
		logic       mix_clr;
		logic       g_mul;
		logic       g_add;
		logic [1:0] g_k;
	} cmd_t;

	// word address of quarter position j of quarter q in round r (rows 0-7, columns 8-15)
	function automatic logic [6:0] word_idx(input logic [3:0] r, input logic [2:0] q,
			input logic [1:0] j);
		logic [1:0] col;
		logic [3:0] kk;
		logic [6:0] res;
		col = q[1:0] + (q[2] ? j : 2'd0);
		kk = {j, col};
		if (!r[3]) begin
			res = {r[2:0], kk};
		end else begin
			res = {kk[3:1], r[2:0], kk[0]};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[src/a2bc_ctrl.sv]
// Sequencer for seed fetch, S-box mix, BlaMka rounds and result emission.
`default_nettype none
module a2bc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic          use_sbox,
	output logic               busy,
	output a2bc_pkg::cmd_t     cmd
);
	import a2bc_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SEED0 = 13'b0000000000010,
		S_SEED1 = 13'b0000000000100,
		S_SEEDW = 13'b0000000001000,
		S_MCLR  = 13'b0000000010000,
		S_MMUL  = 13'b0000000100000,
		S_MUPD  = 13'b0000001000000,
		S_QRD   = 13'b0000010000000,
		S_GMUL  = 13'b0000100000000,
		S_GADD  = 13'b0001000000000,
		S_QWR   = 13'b0010000000000,
		S_EMIT  = 13'b0100000000000,
		S_EDR   = 13'b1000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic [6:0] rq_q, rq_d;     // {round, quarter}
	logic [6:0] step_q, step_d;
	logic [6:0] w_q, w_d;
	logic       use_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		rq_d = rq_q;
		step_d = step_q;
		w_d = w_q;
		cmd = '0;
		cmd.rd_dst = DST_NONE;
		case (state_q)
			S_IDLE: begin
				if (go) state_d = S_SEED0;
			end
			S_SEED0: begin
				cmd.rd_addr = 7'd0;
				cmd.rd_dst = DST_SEED0;
				state_d = S_SEED1;
			end
			S_SEED1: begin
				cmd.rd_addr = LAST_WORD_IDX;
				cmd.rd_dst = DST_SEED1;
				state_d = S_SEEDW;
			end
			S_SEEDW: begin
				state_d = use_q ? S_MMUL : S_MCLR;
			end
			S_MCLR: begin
				cmd.mix_clr = 1'b1;
				state_d = S_QRD;
			end
			S_MMUL: begin
				cmd.mix_mul = 1'b1;
				state_d = S_MUPD;
			end
			S_MUPD: begin
				cmd.mix_upd = 1'b1;
				if (step_q == 7'(MIX_STEPS - 1)) begin
					step_d = 7'd0;
					state_d = S_QRD;
				end else begin
					step_d = step_q + 7'd1;
					state_d = S_MMUL;
				end
			end
			S_QRD: begin
				cmd.rd_addr = word_idx(rq_q[6:3], rq_q[2:0], cnt_q);
				cmd.rd_dst = DST_QUAD;
				cmd.rd_j = cnt_q;
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) state_d = S_GMUL;
			end
			S_GMUL: begin
				cmd.g_mul = 1'b1;
				cmd.g_k = cnt_q;
				state_d = S_GADD;
			end
			S_GADD: begin
				cmd.g_add = 1'b1;
				cmd.g_k = cnt_q;
				cnt_d = cnt_q + 2'd1;
				state_d = (cnt_q == 2'd3) ? S_QWR : S_GMUL;
			end
			S_QWR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = word_idx(rq_q[6:3], rq_q[2:0], cnt_q);
				cmd.wr_j = cnt_q;
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					rq_d = rq_q + 7'd1;
					state_d = (rq_q == 7'd127) ? S_EMIT : S_QRD;
				end
			end
			S_EMIT: begin
				cmd.rd_addr = w_q;
				cmd.rd_dst = DST_EMIT;
				w_d = w_q + 7'd1;
				if (w_q == LAST_WORD_IDX) state_d = S_EDR;
			end
			S_EDR: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 2'd0;
			rq_q <= 7'd0;
			step_q <= 7'd0;
			w_q <= 7'd0;
			use_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rq_q <= rq_d;
			step_q <= step_d;
			w_q <= w_d;
			if (go && state_q == S_IDLE) use_q <= use_sbox;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

[src/a2bc_datapath.sv]
// Stores, shared multiplier, BlaMka step unit, mix register and result registers.
`default_nettype none
module a2bc_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           ld_en,
	input  wire logic           ld_op,
	input  wire logic [9:0]     ld_idx,
	input  wire logic [63:0]    sbox_value,
	input  wire logic [63:0]    prev_word,
	input  wire logic [63:0]    ref_word,
	input  wire logic [63:0]    old_word,
	input  wire logic           xor_mode,
	input  wire a2bc_pkg::cmd_t cmd,
	output logic [63:0]         word_even,
	output logic [63:0]         word_odd,
	output logic [5:0]          pair_index,
	output logic                last_pair,
	output logic                done
);
	import a2bc_pkg::*;

	logic [63:0] sbox_mem [1024];
	logic [63:0] base_mem [128];
	logic [63:0] work_mem [128];

	logic [63:0] sb_lo_q, sb_hi_q, work_rd_q, base_rd_q;
	rd_dst_t     dst_s1;
	logic [1:0]  j_s1;
	logic [6:0]  addr_s1;
	logic [63:0] qv_q [4];
	logic [63:0] v_q, prod_q, even_q;
	logic        done_q;

	logic [63:0] r_in, x, y, z, t, zr, word;
	logic [31:0] ma, mb;
	logic        ld_blk;

	function automatic logic [63:0] rot(input logic [63:0] v, input logic [1:0] k);
		logic [63:0] res;
		case (k)
			2'd0: res = {v[31:0], v[63:32]};
			2'd1: res = {v[23:0], v[63:24]};
			2'd2: res = {v[15:0], v[63:16]};
			2'd3: res = {v[62:0], v[63]};
			default: res = v;
		endcase
		return res;
	endfunction

	assign ld_blk = ld_en && (ld_op == OP_BLOCK);
	assign r_in = prev_word ^ ref_word;

	always_ff @(posedge clk) begin
		if (ld_en && ld_op == OP_SBOX) sbox_mem[ld_idx] <= sbox_value;
		sb_lo_q <= sbox_mem[{1'b0, v_q[40:32]}];
		sb_hi_q <= sbox_mem[{1'b1, v_q[8:0]}];
	end

	always_ff @(posedge clk) begin
		if (ld_blk) begin
			work_mem[ld_idx[6:0]] <= r_in;
			base_mem[ld_idx[6:0]] <= xor_mode ? (old_word ^ r_in) : r_in;
		end else if (cmd.wr_en) begin
			work_mem[cmd.wr_addr] <= qv_q[cmd.wr_j];
		end
		work_rd_q <= work_mem[cmd.rd_addr];
		base_rd_q <= base_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_s1 <= DST_NONE;
		end else begin
			dst_s1 <= cmd.rd_dst;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= cmd.rd_j;
		addr_s1 <= cmd.rd_addr;
	end

	// one step unit: odd steps work on c += d, b ^= c; even ones on a += b, d ^= a
	assign x = cmd.g_k[0] ? qv_q[2] : qv_q[0];
	assign y = cmd.g_k[0] ? qv_q[3] : qv_q[1];
	assign z = cmd.g_k[0] ? qv_q[1] : qv_q[3];
	assign t = x + y + {prod_q[62:0], 1'b0};
	assign zr = rot(z ^ t, cmd.g_k);

	assign ma = cmd.mix_mul ? v_q[63:32] : (x[31:0] & LOW32);
	assign mb = cmd.mix_mul ? v_q[31:0] : (y[31:0] & LOW32);

	always_ff @(posedge clk) begin
		if (cmd.mix_mul || cmd.g_mul) prod_q <= ma * mb;
		if (dst_s1 == DST_QUAD) begin
			qv_q[j_s1] <= work_rd_q;
		end else if (cmd.g_add) begin
			if (cmd.g_k[0]) begin
				qv_q[2] <= t;
				qv_q[1] <= zr;
			end else begin
				qv_q[0] <= t;
				qv_q[3] <= zr;
			end
		end
		if (dst_s1 == DST_SEED0) v_q <= work_rd_q;
		else if (dst_s1 == DST_SEED1) v_q <= v_q ^ work_rd_q;
		else if (cmd.mix_clr) v_q <= 64'd0;
		else if (cmd.mix_upd) v_q <= (prod_q + sb_lo_q) ^ sb_hi_q;
	end

	// mix value lands on the first and last word only
	always_comb begin
		word = base_rd_q ^ work_rd_q;
		if (addr_s1 == 7'd0 || addr_s1 == LAST_WORD_IDX) word = word + v_q;
	end

	always_ff @(posedge clk) begin
		if (dst_s1 == DST_EMIT) begin
			if (!addr_s1[0]) begin
				even_q <= word;
			end else begin
				word_even <= even_q;
				word_odd <= word;
				pair_index <= addr_s1[6:1];
				last_pair <= &addr_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (dst_s1 == DST_EMIT) && addr_s1[0];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

[src/argon2_block_compress.sv]
// Top level: Argon2 block compression with BlaMka rounds and optional S-box mix.
// Loads are taken whenever busy is low; busy stays low while loading.
// After the last word: seed fetch, then the S-box mix (a clear of the mix value without S-box),
// 128 quarter rounds that read and write the work store one word at a time, then emission.
// Results: 64 pairs, each beat shown for one cycle; the receiver cannot stall.
// Reset (arst_n low) clears control, config and strobes; stores hold no reset value.
`default_nettype none
module argon2_block_compress (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [9:0]  word_index,
	input  wire logic [63:0] sbox_value,
	input  wire logic [63:0] prev_word,
	input  wire logic [63:0] ref_word,
	input  wire logic [63:0] old_word,
	input  wire logic        last_word,
	output logic             done,
	output logic [63:0]      word_even,
	output logic [63:0]      word_odd,
	output logic [5:0]       pair_index,
	output logic             last_pair,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data
);
	import a2bc_pkg::*;

	logic accept, go, xor_mode_q, use_sbox_q;
	cmd_t cmd;

	assign accept = start && !busy;
	assign go = accept && (opcode == OP_BLOCK) && last_word;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_mode_q <= 1'b0;
			use_sbox_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_XOR_MODE) xor_mode_q <= cfg_data;
			if (cfg_index == CFG_USE_SBOX) use_sbox_q <= cfg_data;
		end
	end

	a2bc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .use_sbox(use_sbox_q),
		.busy(busy), .cmd(cmd)
	);

	a2bc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ld_en(accept), .ld_op(opcode),
		.ld_idx(word_index), .sbox_value(sbox_value), .prev_word(prev_word),
		.ref_word(ref_word), .old_word(old_word), .xor_mode(xor_mode_q), .cmd(cmd),
		.word_even(word_even), .word_odd(word_odd), .pair_index(pair_index),
		.last_pair(last_pair), .done(done)
	);

`ifndef SYNTHESIS
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last_pair) |-> busy) else $error("pair beat while idle");
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_pair) |=> !done) else $error("beat after last pair");
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode && last_word) |=> busy) else $error("start not taken");
	a_pair_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pair_index != 6'd0) |->
		($past(done, 2) && $past(pair_index, 2) == pair_index - 6'd1))
		else $error("pair order broken");
`endif

endmodule
`default_nettype wire
